FILE: hw/rtl/wljc_pkg.sv
// ----------------------------------------------------------------------------
// Wide line joint corners: shared types and constants
// Packed request and result types, fixed-point constants and the latency
// of the vector normalizer.
// ----------------------------------------------------------------------------
package wljc_pkg;

    localparam int COORD_BITS = 32;
    localparam int WIDTH_BITS = 31;

    // Latency of wljc_norm in cycles.
    localparam int NORM_LAT = 70;

    // 1.0 in the Q2.30 unit vector format.
    localparam logic signed [31:0] UNIT_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] mid_x;
        logic signed [COORD_BITS-1:0] mid_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left_x;
        logic signed [COORD_BITS-1:0] left_y;
        logic signed [COORD_BITS-1:0] right_x;
        logic signed [COORD_BITS-1:0] right_y;
        logic                         wide_turn;
    } out_t;

endpackage

FILE: hw/rtl/wljc_norm.sv
// ----------------------------------------------------------------------------
// Wide line joint corners: vector normalizer
// Pipelined unit vector of a 33-bit signed vector in Q2.30: magnitude
// scaling, squared length, digit-by-digit square root and two restoring
// dividers, one step per stage. A zero vector gives (1, 0).
// ----------------------------------------------------------------------------
module wljc_norm import wljc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [32:0] in_x,
    input  logic signed [32:0] in_y,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);

    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 31;

    typedef struct packed {
        logic negx;
        logic negy;
        logic zero;
    } nflag_t;

    typedef struct packed {
        logic [32:0] ax;
        logic [32:0] ay;
        logic        negx;
        logic        negy;
    } nabs_t;

    typedef struct packed {
        logic [32:0] ax;
        logic [32:0] ay;
        logic [5:0]  pos;
        nflag_t      flag;
    } npos_t;

    typedef struct packed {
        logic [30:0] ax;
        logic [30:0] ay;
        nflag_t      flag;
    } nsh_t;

    typedef struct packed {
        logic [61:0] sqx;
        logic [61:0] sqy;
        logic [30:0] ax;
        logic [30:0] ay;
        nflag_t      flag;
    } nsqr_t;

    typedef struct packed {
        logic [63:0] n;
        logic [32:0] rem;
        logic [31:0] root;
        logic [30:0] ax;
        logic [30:0] ay;
        nflag_t      flag;
    } nsq_t;

    typedef struct packed {
        logic [31:0] remx;
        logic [31:0] remy;
        logic [30:0] accx;
        logic [30:0] accy;
        logic [31:0] len;
        nflag_t      flag;
    } ndv_t;

    function automatic logic [30:0] scale(logic [32:0] a, logic [5:0] p);
        logic [30:0] r;
        if (p > 6'd30) begin
            r = 31'(a >> (p - 6'd30));
        end else begin
            r = 31'(a << (6'd30 - p));
        end
        return r;
    endfunction

    // One root bit per step, two radicand bits brought in each time.
    function automatic nsq_t sqrt_step(nsq_t s);
        logic [34:0] r2;
        logic [34:0] trial;
        nsq_t        o;
        r2    = {s.rem, s.n[63:62]};
        trial = {1'b0, s.root, 2'b01};
        o     = s;
        o.n   = {s.n[61:0], 2'b00};
        if (r2 >= trial) begin
            o.rem  = 33'(r2 - trial);
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = r2[32:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic ndv_t div_step(ndv_t s);
        logic [32:0] tx;
        logic [32:0] ty;
        ndv_t        o;
        o  = s;
        tx = {s.remx, s.accx[30]};
        ty = {s.remy, s.accy[30]};
        if (tx >= {1'b0, s.len}) begin
            o.remx = 32'(tx - {1'b0, s.len});
            o.accx = {s.accx[29:0], 1'b1};
        end else begin
            o.remx = tx[31:0];
            o.accx = {s.accx[29:0], 1'b0};
        end
        if (ty >= {1'b0, s.len}) begin
            o.remy = 32'(ty - {1'b0, s.len});
            o.accy = {s.accy[29:0], 1'b1};
        end else begin
            o.remy = ty[31:0];
            o.accy = {s.accy[29:0], 1'b0};
        end
        return o;
    endfunction

    nabs_t              abs_reg,  abs_next;
    npos_t              pos_reg,  pos_next;
    nsh_t               sh_reg,   sh_next;
    nsqr_t              sqr_reg,  sqr_next;
    nsq_t               sq_reg [0:SQ_STEPS];
    nsq_t               sq_next;
    ndv_t               dv_reg [0:DV_STEPS];
    ndv_t               dv_next;
    logic signed [31:0] ux_reg,   ux_next;
    logic signed [31:0] uy_reg,   uy_next;
    logic        [32:0] max_mag;

    always_comb begin
        abs_next.negx = in_x[32];
        abs_next.negy = in_y[32];
        abs_next.ax   = in_x[32] ? 33'(-in_x) : 33'(in_x);
        abs_next.ay   = in_y[32] ? 33'(-in_y) : 33'(in_y);
    end

    // Leading one of the larger magnitude sets the common scaling shift.
    always_comb begin
        max_mag            = (abs_reg.ax > abs_reg.ay) ? abs_reg.ax : abs_reg.ay;
        pos_next.ax        = abs_reg.ax;
        pos_next.ay        = abs_reg.ay;
        pos_next.flag.negx = abs_reg.negx;
        pos_next.flag.negy = abs_reg.negy;
        pos_next.flag.zero = (max_mag == '0);
        pos_next.pos       = '0;
        for (int i = 0; i < 33; i++) begin
            if (max_mag[i]) begin
                pos_next.pos = 6'(i);
            end
        end
    end

    always_comb begin
        sh_next.ax   = scale(pos_reg.ax, pos_reg.pos);
        sh_next.ay   = scale(pos_reg.ay, pos_reg.pos);
        sh_next.flag = pos_reg.flag;
    end

    always_comb begin
        sqr_next.sqx  = sh_reg.ax * sh_reg.ax;
        sqr_next.sqy  = sh_reg.ay * sh_reg.ay;
        sqr_next.ax   = sh_reg.ax;
        sqr_next.ay   = sh_reg.ay;
        sqr_next.flag = sh_reg.flag;
    end

    always_comb begin
        sq_next.n    = {1'b0, 63'(sqr_reg.sqx + sqr_reg.sqy)};
        sq_next.rem  = '0;
        sq_next.root = '0;
        sq_next.ax   = sqr_reg.ax;
        sq_next.ay   = sqr_reg.ay;
        sq_next.flag = sqr_reg.flag;
    end

    // Dividend is a << 30; its top bits start as the partial remainder.
    always_comb begin
        dv_next.remx = {2'b00, sq_reg[SQ_STEPS].ax[30:1]};
        dv_next.remy = {2'b00, sq_reg[SQ_STEPS].ay[30:1]};
        dv_next.accx = {sq_reg[SQ_STEPS].ax[0], 30'd0};
        dv_next.accy = {sq_reg[SQ_STEPS].ay[0], 30'd0};
        dv_next.len  = sq_reg[SQ_STEPS].root;
        dv_next.flag = sq_reg[SQ_STEPS].flag;
    end

    always_comb begin
        if (dv_reg[DV_STEPS].flag.zero) begin
            ux_next = UNIT_ONE;
            uy_next = '0;
        end else begin
            ux_next = dv_reg[DV_STEPS].flag.negx ? -$signed({1'b0, dv_reg[DV_STEPS].accx})
                                                 : $signed({1'b0, dv_reg[DV_STEPS].accx});
            uy_next = dv_reg[DV_STEPS].flag.negy ? -$signed({1'b0, dv_reg[DV_STEPS].accy})
                                                 : $signed({1'b0, dv_reg[DV_STEPS].accy});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg   <= abs_next;
            pos_reg   <= pos_next;
            sh_reg    <= sh_next;
            sqr_reg   <= sqr_next;
            sq_reg[0] <= sq_next;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
            end
            dv_reg[0] <= dv_next;
            for (int k = 0; k < DV_STEPS; k++) begin
                dv_reg[k+1] <= div_step(dv_reg[k]);
            end
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end
    end

    assign out_x = ux_reg;
    assign out_y = uy_reg;

endmodule

FILE: hw/rtl/wide_line_joint_corners_core.sv
// ----------------------------------------------------------------------------
// Wide line joint corners
// Miter joint of two wide polyline segments: from three consecutive points
// it gives the left and right corner points at the joint and a flag for
// turns sharper than 135 degrees.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Moves
//   input     s_valid, s_ready, s_data       one point triple per request
//   result    m_valid, m_ready, m_data       two corners and the turn flag
//   config    cfg_valid, cfg_ready, cfg_data line width, Q15.16 magnitude
//
// One request is taken per cycle while the output is not stalled.
// The latency comes from two normalizer passes (square root and dividers,
// one bit per stage) and the 61-stage offset divider.
// Reset clears all valid bits and sets the line width to 1.0.
// While a result waits at the output, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module wide_line_joint_corners_core import wljc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WIDTH_BITS-1:0] cfg_data
);

    localparam int FD_STEPS = 61;
    localparam int LAT      = 2 + NORM_LAT + 5 + NORM_LAT + 4 + FD_STEPS + 1 + 1;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RST = WIDTH_BITS'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } mid_t;

    typedef struct packed {
        logic signed [32:0] d0x;
        logic signed [32:0] d0y;
        logic signed [32:0] d1x;
        logic signed [32:0] d1y;
        mid_t               mid;
    } diff_t;

    typedef struct packed {
        logic signed [31:0] u0x;
        logic signed [31:0] u0y;
        logic signed [32:0] jsx;
        logic signed [32:0] jsy;
        logic signed [63:0] pxx;
        logic signed [63:0] pyy;
        logic signed [63:0] dot;
        logic               dneg;
        logic        [31:0] d;
        logic        [63:0] dd;
        logic               eps;
        logic               wide;
        mid_t               mid;
    } jst_t;

    typedef struct packed {
        logic signed [31:0] u0x;
        logic signed [31:0] u0y;
        logic               eps;
        logic               wide;
        mid_t               mid;
    } side_t;

    typedef struct packed {
        logic signed [31:0] u0x;
        logic signed [31:0] u0y;
        logic signed [31:0] jx;
        logic signed [31:0] jy;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] s;
        logic               wide;
        mid_t               mid;
    } kst_t;

    typedef struct packed {
        logic [30:0] ajx;
        logic [30:0] ajy;
        logic        negx;
        logic        negy;
        logic [32:0] dvs;
        logic        wide;
        mid_t        mid;
    } sin_t;

    typedef struct packed {
        logic [31:0] remx;
        logic [31:0] remy;
        logic [60:0] accx;
        logic [60:0] accy;
        logic [32:0] dvs;
        logic        negx;
        logic        negy;
        logic        wide;
        mid_t        mid;
    } fd_t;

    function automatic fd_t fd_step(fd_t s);
        logic [32:0] tx;
        logic [32:0] ty;
        fd_t         o;
        o  = s;
        tx = {s.remx, s.accx[60]};
        ty = {s.remy, s.accy[60]};
        if (tx >= s.dvs) begin
            o.remx = 32'(tx - s.dvs);
            o.accx = {s.accx[59:0], 1'b1};
        end else begin
            o.remx = tx[31:0];
            o.accx = {s.accx[59:0], 1'b0};
        end
        if (ty >= s.dvs) begin
            o.remy = 32'(ty - s.dvs);
            o.accy = {s.accy[59:0], 1'b1};
        end else begin
            o.remy = ty[31:0];
            o.accy = {s.accy[59:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [62:0] v);
        logic signed [31:0] r;
        if (v > 63'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -63'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic                  adv;
    logic [LAT-1:0]        vld_reg;
    logic [WIDTH_BITS-1:0] line_width_reg;

    in_t                in_reg;
    diff_t              diff_reg, diff_next;
    mid_t               dl1_reg [0:NORM_LAT-1];
    side_t              dl2_reg [0:NORM_LAT-1];
    side_t              side_next;
    jst_t               j1_reg, j1_next;
    jst_t               j2_reg, j2_next;
    jst_t               j3_reg, j3_next;
    jst_t               j4_reg, j4_next;
    jst_t               j5_reg, j5_next;
    kst_t               k1_reg, k1_next;
    kst_t               k2_reg, k2_next;
    kst_t               k3_reg, k3_next;
    sin_t               k4_reg, k4_next;
    fd_t                fd_reg [0:FD_STEPS];
    fd_t                fd_next;
    out_t               out_reg, out_next;

    logic signed [31:0] u0x, u0y, u1x, u1y, njx, njy;
    logic signed [31:0] jx0, jy0;
    logic signed [63:0] dot_abs, s_abs;
    logic        [31:0] s30;
    logic signed [62:0] mid_ex, mid_ey, acc_ex, acc_ey;
    side_t              side_out;
    fd_t                fd_last;

    assign adv       = !vld_reg[LAT-1] || m_ready;
    assign s_ready   = adv;
    assign m_valid   = vld_reg[LAT-1];
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            line_width_reg <= WIDTH_RST;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            if (cfg_valid) begin
                line_width_reg <= cfg_data;
            end
        end
    end

    // Segment vectors.
    always_comb begin
        diff_next.d0x = 33'(in_reg.mid_x) - 33'(in_reg.start_x);
        diff_next.d0y = 33'(in_reg.mid_y) - 33'(in_reg.start_y);
        diff_next.d1x = 33'(in_reg.end_x) - 33'(in_reg.mid_x);
        diff_next.d1y = 33'(in_reg.end_y) - 33'(in_reg.mid_y);
        diff_next.mid.x = in_reg.mid_x;
        diff_next.mid.y = in_reg.mid_y;
    end

    wljc_norm u_norm0 (
        .aclk  (aclk),
        .en    (adv),
        .in_x  (diff_reg.d0x),
        .in_y  (diff_reg.d0y),
        .out_x (u0x),
        .out_y (u0y)
    );

    wljc_norm u_norm1 (
        .aclk  (aclk),
        .en    (adv),
        .in_x  (diff_reg.d1x),
        .in_y  (diff_reg.d1y),
        .out_x (u1x),
        .out_y (u1y)
    );

    // Direction sum, dot product and the sharp-turn test.
    always_comb begin
        j1_next      = '0;
        j1_next.u0x  = u0x;
        j1_next.u0y  = u0y;
        j1_next.jsx  = 33'(u0x) + 33'(u1x);
        j1_next.jsy  = 33'(u0y) + 33'(u1y);
        j1_next.pxx  = u0x * u1x;
        j1_next.pyy  = u0y * u1y;
        j1_next.mid  = dl1_reg[NORM_LAT-1];

        j2_next      = j1_reg;
        j2_next.dot  = j1_reg.pxx + j1_reg.pyy;
        j2_next.eps  = (j1_reg.jsx >= -33'sd4) && (j1_reg.jsx <= 33'sd4) &&
                       (j1_reg.jsy >= -33'sd4) && (j1_reg.jsy <= 33'sd4);

        dot_abs      = j2_reg.dot[63] ? -j2_reg.dot : j2_reg.dot;
        j3_next      = j2_reg;
        j3_next.dneg = j2_reg.dot[63];
        j3_next.d    = dot_abs[61:30];

        j4_next      = j3_reg;
        j4_next.dd   = j3_reg.d * j3_reg.d;

        j5_next      = j4_reg;
        j5_next.wide = j4_reg.dneg && (j4_reg.dd > 64'h0800_0000_0000_0000);

        side_next.u0x  = j5_reg.u0x;
        side_next.u0y  = j5_reg.u0y;
        side_next.eps  = j5_reg.eps;
        side_next.wide = j5_reg.wide;
        side_next.mid  = j5_reg.mid;
    end

    wljc_norm u_normj (
        .aclk  (aclk),
        .en    (adv),
        .in_x  (j5_reg.jsx),
        .in_y  (j5_reg.jsy),
        .out_x (njx),
        .out_y (njy)
    );

    // Junction direction, its orientation and the sine against the first
    // segment.
    always_comb begin
        side_out = dl2_reg[NORM_LAT-1];
        // On a reversal the first direction turned left stands in.
        jx0 = side_out.eps ? -side_out.u0y : njx;
        jy0 = side_out.eps ? side_out.u0x : njy;

        k1_next      = '0;
        k1_next.u0x  = side_out.u0x;
        k1_next.u0y  = side_out.u0y;
        k1_next.wide = side_out.wide;
        k1_next.mid  = side_out.mid;
        if (side_out.wide) begin
            k1_next.jx = jx0;
            k1_next.jy = jy0;
        end else begin
            k1_next.jx = -jy0;
            k1_next.jy = jx0;
        end

        k2_next   = k1_reg;
        k2_next.a = k1_reg.u0x * k1_reg.jy;
        k2_next.b = k1_reg.u0y * k1_reg.jx;

        k3_next   = k2_reg;
        k3_next.s = k2_reg.a - k2_reg.b;

        // A negative sine flips the junction direction; only signs change.
        s_abs        = k3_reg.s[63] ? -k3_reg.s : k3_reg.s;
        s30          = (s_abs[61:30] == '0) ? 32'(UNIT_ONE) : s_abs[61:30];
        k4_next.dvs  = {s30, 1'b0};
        k4_next.ajx  = k3_reg.jx[31] ? 31'(-k3_reg.jx) : 31'(k3_reg.jx);
        k4_next.ajy  = k3_reg.jy[31] ? 31'(-k3_reg.jy) : 31'(k3_reg.jy);
        k4_next.negx = k3_reg.jx[31] ^ k3_reg.s[63];
        k4_next.negy = k3_reg.jy[31] ^ k3_reg.s[63];
        k4_next.wide = k3_reg.wide;
        k4_next.mid  = k3_reg.mid;

        fd_next.remx = '0;
        fd_next.remy = '0;
        fd_next.accx = 61'(line_width_reg * k4_reg.ajx);
        fd_next.accy = 61'(line_width_reg * k4_reg.ajy);
        fd_next.dvs  = k4_reg.dvs;
        fd_next.negx = k4_reg.negx;
        fd_next.negy = k4_reg.negy;
        fd_next.wide = k4_reg.wide;
        fd_next.mid  = k4_reg.mid;
    end

    // Corners at mid +/- offset, saturated.
    always_comb begin
        fd_last = fd_reg[FD_STEPS];
        mid_ex  = 63'(fd_last.mid.x);
        mid_ey  = 63'(fd_last.mid.y);
        acc_ex  = $signed({2'b00, fd_last.accx});
        acc_ey  = $signed({2'b00, fd_last.accy});
        out_next.left_x    = sat32(fd_last.negx ? mid_ex - acc_ex : mid_ex + acc_ex);
        out_next.right_x   = sat32(fd_last.negx ? mid_ex + acc_ex : mid_ex - acc_ex);
        out_next.left_y    = sat32(fd_last.negy ? mid_ey - acc_ey : mid_ey + acc_ey);
        out_next.right_y   = sat32(fd_last.negy ? mid_ey + acc_ey : mid_ey - acc_ey);
        out_next.wide_turn = fd_last.wide;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg     <= s_data;
            diff_reg   <= diff_next;
            dl1_reg[0] <= diff_reg.mid;
            for (int i = 1; i < NORM_LAT; i++) begin
                dl1_reg[i] <= dl1_reg[i-1];
            end
            j1_reg     <= j1_next;
            j2_reg     <= j2_next;
            j3_reg     <= j3_next;
            j4_reg     <= j4_next;
            j5_reg     <= j5_next;
            dl2_reg[0] <= side_next;
            for (int i = 1; i < NORM_LAT; i++) begin
                dl2_reg[i] <= dl2_reg[i-1];
            end
            k1_reg    <= k1_next;
            k2_reg    <= k2_next;
            k3_reg    <= k3_next;
            k4_reg    <= k4_next;
            fd_reg[0] <= fd_next;
            for (int k = 0; k < FD_STEPS; k++) begin
                fd_reg[k+1] <= fd_step(fd_reg[k]);
            end
            out_reg <= out_next;
        end
    end

endmodule
